// ===== rtl/bdpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned MsWidth      = 16;
  localparam int unsigned NowWidth     = 32;
  localparam int unsigned InDataWidth  = 40;
  localparam int unsigned OutDataWidth = 8;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_ACTIVE_LOW      = 3'd0,
    CFG_DEBOUNCE        = 3'd1,
    CFG_LONG_PRESS      = 3'd2,
    CFG_VERY_LONG_PRESS = 3'd3,
    CFG_REPEAT_START    = 3'd4,
    CFG_REPEAT_INTERVAL = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_SHORT     = 3'd1,
    EV_LONG      = 3'd2,
    EV_VERY_LONG = 3'd3,
    EV_REPEAT    = 3'd4,
    EV_RELEASED  = 3'd5
  } event_e;

  typedef struct packed {
    logic               active_low;
    logic [MsWidth-1:0] debounce_ms;
    logic [MsWidth-1:0] long_press_ms;
    logic [MsWidth-1:0] very_long_press_ms;
    logic [MsWidth-1:0] repeat_start_ms;
    logic [MsWidth-1:0] repeat_interval_ms;
  } cfg_t;

endpackage

// ===== rtl/bdpc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module bdpc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bdpc_pkg::CfgIdxWidth-1:0]    cfg_addr_i,
  input  logic [bdpc_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output bdpc_pkg::cfg_t                      cfg_o
);
  import bdpc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_ACTIVE_LOW:      cfg_d.active_low         = cfg_data_i[0];
        CFG_DEBOUNCE:        cfg_d.debounce_ms        = cfg_data_i;
        CFG_LONG_PRESS:      cfg_d.long_press_ms      = cfg_data_i;
        CFG_VERY_LONG_PRESS: cfg_d.very_long_press_ms = cfg_data_i;
        CFG_REPEAT_START:    cfg_d.repeat_start_ms    = cfg_data_i;
        CFG_REPEAT_INTERVAL: cfg_d.repeat_interval_ms = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_low         <= 1'b1;
      cfg_q.debounce_ms        <= 16'd50;
      cfg_q.long_press_ms      <= 16'd1000;
      cfg_q.very_long_press_ms <= 16'd3000;
      cfg_q.repeat_start_ms    <= 16'd1500;
      cfg_q.repeat_interval_ms <= 16'd200;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/bdpc_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_classify
// Debounce and press timing state with the one-step classification logic.
// ----------------------------------------------------------------------------
module bdpc_classify #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bdpc_pkg::cfg_t                    cfg_i,
  input  logic                              step_i,
  input  logic                              pin_level_i,
  input  logic [bdpc_pkg::NowWidth-1:0]     now_ms_i,
  output bdpc_pkg::event_e                  event_o
);
  import bdpc_pkg::*;

  logic                 last_raw_q, last_raw_d;
  logic [TIME_BITS-1:0] last_change_q, last_change_d;
  logic                 stable_q, stable_d;
  logic [TIME_BITS-1:0] press_start_q, press_start_d;
  logic                 long_fired_q, long_fired_d;
  logic                 vlong_fired_q, vlong_fired_d;
  logic [TIME_BITS-1:0] last_repeat_q, last_repeat_d;

  logic                 raw;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] since_change, held, since_repeat;
  logic [TIME_BITS-1:0] deb_t, long_t, vlong_t, rep_start_t, rep_int_t;

  assign raw          = cfg_i.active_low ? ~pin_level_i : pin_level_i;
  assign now_t        = TIME_BITS'(now_ms_i);
  assign since_change = now_t - last_change_q;
  assign held         = now_t - press_start_q;
  assign since_repeat = now_t - last_repeat_q;
  assign deb_t        = TIME_BITS'(cfg_i.debounce_ms);
  assign long_t       = TIME_BITS'(cfg_i.long_press_ms);
  assign vlong_t      = TIME_BITS'(cfg_i.very_long_press_ms);
  assign rep_start_t  = TIME_BITS'(cfg_i.repeat_start_ms);
  assign rep_int_t    = TIME_BITS'(cfg_i.repeat_interval_ms);

  always_comb begin
    last_raw_d    = last_raw_q;
    last_change_d = last_change_q;
    stable_d      = stable_q;
    press_start_d = press_start_q;
    long_fired_d  = long_fired_q;
    vlong_fired_d = vlong_fired_q;
    last_repeat_d = last_repeat_q;
    event_o       = EV_NONE;

    if (raw != last_raw_q) begin
      // Any level change only restarts the settle timer.
      last_raw_d    = raw;
      last_change_d = now_t;
    end else if (since_change < deb_t) begin
      event_o = EV_NONE;
    end else if (raw && !stable_q) begin
      stable_d      = 1'b1;
      press_start_d = now_t;
      long_fired_d  = 1'b0;
      vlong_fired_d = 1'b0;
      last_repeat_d = now_t;
    end else if (raw) begin
      // At most one event per word, in priority order long, very long, repeat.
      if (!long_fired_q && held >= long_t) begin
        long_fired_d = 1'b1;
        event_o      = EV_LONG;
      end else if (!vlong_fired_q && held >= vlong_t) begin
        vlong_fired_d = 1'b1;
        event_o       = EV_VERY_LONG;
      end else if (long_fired_q && !vlong_fired_q && held >= rep_start_t &&
                   since_repeat >= rep_int_t) begin
        last_repeat_d = now_t;
        event_o       = EV_REPEAT;
      end
    end else if (stable_q) begin
      stable_d      = 1'b0;
      long_fired_d  = 1'b0;
      vlong_fired_d = 1'b0;
      if (long_fired_q) begin
        event_o = EV_RELEASED;
      end else if (held >= deb_t) begin
        event_o = EV_SHORT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q    <= 1'b0;
      last_change_q <= '0;
      stable_q      <= 1'b0;
      press_start_q <= '0;
      long_fired_q  <= 1'b0;
      vlong_fired_q <= 1'b0;
      last_repeat_q <= '0;
    end else if (step_i) begin
      last_raw_q    <= last_raw_d;
      last_change_q <= last_change_d;
      stable_q      <= stable_d;
      press_start_q <= press_start_d;
      long_fired_q  <= long_fired_d;
      vlong_fired_q <= vlong_fired_d;
      last_repeat_q <= last_repeat_d;
    end
  end

endmodule

// ===== rtl/button_debounce_press_classifier_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_core
// Button debouncer with short, long, very long press and repeat events.
// ----------------------------------------------------------------------------
// Each input word carries one raw pin sample and a millisecond timestamp on
// the s_axis channel. For every accepted word exactly one result word leaves
// on m_axis with the event code (none, short, long, very long, repeat or
// released). The input word is registered, classified combinationally against
// the timing state, and the event lands in an output register, from which the
// result can be taken; one word is taken in every cycle while the output
// register is free or drains. The timing state is updated in the same cycle
// as the classification, so the next word always sees the state left by the
// one before it.
// When the receiver stalls, the result stays in the output register and one
// more word may wait in the input register; then s_axis_tready drops.
// Reset clears the timing state (button released at time zero) and loads
// the default thresholds. Configuration words are taken in any cycle and
// should be written only while no word is in flight.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0: pin_level [0], now_ms [32:1], zero fill [39:33].
  input  logic [bdpc_pkg::InDataWidth-1:0]     s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // Fields from bit 0: event_res [2:0], zero fill [7:3].
  output logic [bdpc_pkg::OutDataWidth-1:0]    m_axis_tdata,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bdpc_pkg::CfgIdxWidth-1:0]     cfg_addr_i,
  input  logic [bdpc_pkg::CfgDataWidth-1:0]    cfg_data_i
);
  import bdpc_pkg::*;

  cfg_t                cfg;
  event_e              event_c;
  logic                advance;

  logic                in_valid_q, in_valid_d;
  logic                in_pin_q;
  logic [NowWidth-1:0] in_now_q;
  logic                out_valid_q, out_valid_d;
  event_e              out_event_q;

  // The classify stage moves when it holds a word and the output register is free or drains.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_pin_q <= s_axis_tdata[0];
      in_now_q <= s_axis_tdata[NowWidth:1];
    end
    if (advance) begin
      out_event_q <= event_c;
    end
  end

  bdpc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bdpc_classify #(
    .TIME_BITS (TIME_BITS)
  ) u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (advance),
    .pin_level_i (in_pin_q),
    .now_ms_i    (in_now_q),
    .event_o     (event_c)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataWidth'(out_event_q);

endmodule

// ===== tb/button_debounce_press_classifier_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_core_test
// Self-checking bench for the button debounce and press classifier core.
// ----------------------------------------------------------------------------
// A short table of pin samples runs first against the reset thresholds. Then
// random press sequences, bounce and timestamp noise are sent under several
// threshold settings. A behavioral model of the debouncer predicts one event
// per accepted word, and every result word is compared with the oldest
// prediction. Both stream sides idle at random, and the result side also
// holds off for long stretches so that the core backs up.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_core_test;
  import bdpc_pkg::*;

  localparam logic [CfgIdxWidth-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxWidth-1:0] CFG_SPARE_HI = 3'd7;
  localparam int unsigned HoldOffCycles = 80;

  typedef struct packed {
    logic        last_raw;
    logic [31:0] last_change_ms;
    logic        stable_pressed;
    logic [31:0] press_start_ms;
    logic        long_fired;
    logic        very_long_fired;
    logic [31:0] last_repeat_ms;
  } button_state_t;

  typedef struct packed {
    logic        pin;
    logic [31:0] now_ms;
    logic        typed;
    event_e      ev;
  } sample_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  // Fields from bit 0: pin_level [0], now_ms [32:1], zero fill [39:33].
  logic [InDataWidth-1:0]  s_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  // Fields from bit 0: event_res [2:0], zero fill [7:3].
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CfgIdxWidth-1:0]  cfg_addr_i;
  logic [CfgDataWidth-1:0] cfg_data_i;

  cfg_t          thr;
  button_state_t btn;
  event_e        pending_events[$];
  sample_row_t   sample_rows[$];
  int unsigned   mismatches;
  int unsigned   words_sent;
  int unsigned   words_seen;
  int unsigned   setting_count;
  int unsigned   event_tally[6];
  logic [31:0]   cur_ms;
  int unsigned   step_max;

  button_debounce_press_classifier_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("Timed out with %0d results outstanding", pending_events.size());
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH after %0d results: %s", words_seen, msg);
    mismatches++;
  endtask

  // Works out the event for one pin sample and advances the button state.
  function automatic event_e next_press_event(input logic pin, input logic [31:0] now_ms);
    logic        pressed;
    logic        had_long;
    logic [31:0] held;
    logic [31:0] settled;
    logic [31:0] since_repeat;
    pressed      = thr.active_low ? ~pin : pin;
    held         = now_ms - btn.press_start_ms;
    settled      = now_ms - btn.last_change_ms;
    since_repeat = now_ms - btn.last_repeat_ms;
    if (pressed != btn.last_raw) begin
      btn.last_raw       = pressed;
      btn.last_change_ms = now_ms;
      return EV_NONE;
    end
    if (settled < {16'd0, thr.debounce_ms}) return EV_NONE;
    if (pressed && !btn.stable_pressed) begin
      btn.stable_pressed  = 1'b1;
      btn.press_start_ms  = now_ms;
      btn.long_fired      = 1'b0;
      btn.very_long_fired = 1'b0;
      btn.last_repeat_ms  = now_ms;
      return EV_NONE;
    end
    if (pressed) begin
      if (!btn.long_fired && held >= {16'd0, thr.long_press_ms}) begin
        btn.long_fired = 1'b1;
        return EV_LONG;
      end
      if (!btn.very_long_fired && held >= {16'd0, thr.very_long_press_ms}) begin
        btn.very_long_fired = 1'b1;
        return EV_VERY_LONG;
      end
      if (btn.long_fired && !btn.very_long_fired && held >= {16'd0, thr.repeat_start_ms} &&
          since_repeat >= {16'd0, thr.repeat_interval_ms}) begin
        btn.last_repeat_ms = now_ms;
        return EV_REPEAT;
      end
      return EV_NONE;
    end
    if (btn.stable_pressed) begin
      had_long            = btn.long_fired;
      btn.stable_pressed  = 1'b0;
      btn.long_fired      = 1'b0;
      btn.very_long_fired = 1'b0;
      if (had_long) return EV_RELEASED;
      if (held >= {16'd0, thr.debounce_ms}) return EV_SHORT;
    end
    return EV_NONE;
  endfunction

  task automatic write_reg(input logic [CfgIdxWidth-1:0] addr, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (addr)
      CFG_ACTIVE_LOW:      thr.active_low = data[0];
      CFG_DEBOUNCE:        thr.debounce_ms = data;
      CFG_LONG_PRESS:      thr.long_press_ms = data;
      CFG_VERY_LONG_PRESS: thr.very_long_press_ms = data;
      CFG_REPEAT_START:    thr.repeat_start_ms = data;
      CFG_REPEAT_INTERVAL: thr.repeat_interval_ms = data;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic al, input logic [15:0] deb, input logic [15:0] lp,
                              input logic [15:0] vlp, input logic [15:0] rs,
                              input logic [15:0] ri);
    logic [15:0] polarity;
    int unsigned mx;
    // Upper bits of the polarity word are don't-care, so they carry noise.
    polarity    = 16'($urandom());
    polarity[0] = al;
    write_reg(CFG_ACTIVE_LOW, polarity);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_LONG_PRESS, lp);
    write_reg(CFG_VERY_LONG_PRESS, vlp);
    write_reg(CFG_REPEAT_START, rs);
    write_reg(CFG_REPEAT_INTERVAL, ri);
    cfg_valid_i <= 1'b0;
    mx = 32'(deb);
    if (32'(lp) > mx) mx = 32'(lp);
    if (32'(vlp) > mx) mx = 32'(vlp);
    if (32'(rs) > mx) mx = 32'(rs);
    // Steps sized so that a hold of a dozen words crosses every threshold.
    step_max = mx / 6 + 2;
    setting_count++;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_events.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic send_sample(input logic pin, input logic [31:0] now_ms, input logic typed,
                             input event_e typed_ev);
    event_e      ev;
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, now_ms, pin};
    do @(posedge clk_i); while (!s_axis_tready);
    ev = next_press_event(pin, now_ms);
    pending_events.push_back(typed ? typed_ev : ev);
    event_tally[ev]++;
    words_sent++;
    if (!(words_sent > 900 && words_sent < 1200) && $urandom_range(99) < 5) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_level(input logic pin, input int unsigned max_step);
    cur_ms = cur_ms + $urandom_range(0, max_step);
    send_sample(pin, cur_ms, 1'b0, EV_NONE);
  endtask

  // Mostly clean presses with bounce around the edges, the rest timestamp noise and single random levels.
  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned n;
    int unsigned bounce_step;
    logic        held_pin;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      held_pin    = thr.active_low ? 1'b0 : 1'b1;
      bounce_step = thr.debounce_ms / 2 + 1;
      kind        = $urandom_range(99);
      if (kind < 75) begin
        n = $urandom_range(0, 3);
        repeat (n) send_level(1'($urandom_range(0, 1)), bounce_step);
        n = $urandom_range(1, 16);
        repeat (n) send_level(held_pin, step_max);
        n = $urandom_range(0, 3);
        repeat (n) send_level(1'($urandom_range(0, 1)), bounce_step);
        n = $urandom_range(1, 4);
        repeat (n) send_level(~held_pin, step_max);
      end else if (kind < 85) begin
        cur_ms = $urandom();
        send_sample(1'($urandom_range(0, 1)), cur_ms, 1'b0, EV_NONE);
      end else if (kind < 93) begin
        cur_ms = cur_ms - $urandom_range(0, step_max);
        send_sample(1'($urandom_range(0, 1)), cur_ms, 1'b0, EV_NONE);
      end else begin
        send_level(1'($urandom_range(0, 1)), step_max);
      end
    end
  endtask

  function automatic logic [15:0] rand_ms();
    int unsigned span;
    span = (1 << $urandom_range(0, 16)) - 1;
    return 16'($urandom_range(0, span));
  endfunction

  task automatic add_row(input logic pin, input logic [31:0] now_ms, input logic typed,
                         input event_e ev);
    sample_rows.push_back('{pin: pin, now_ms: now_ms, typed: typed, ev: ev});
  endtask

  initial begin : result_check
    int unsigned hold_left;
    int unsigned next_hold;
    event_e      want;
    logic [7:0]  got;
    hold_left = 0;
    next_hold = 400;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        words_seen++;
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("result word %02h with no sample waiting", got));
        end else begin
          want = pending_events.pop_front();
          if (got[2:0] != want)
            report_mismatch($sformatf("event %0d, predicted %s", got[2:0], want.name()));
          if (got[7:3] != 5'd0)
            report_mismatch($sformatf("fill bits %02h are not zero", got[7:3]));
        end
      end
      if (words_seen >= next_hold && hold_left == 0) begin
        hold_left = HoldOffCycles;
        next_hold += 900;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (words_seen > 600 && words_seen < 850) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 11);
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_addr_i    <= '0;
    cfg_data_i    <= '0;
    thr.active_low         = 1'b1;
    thr.debounce_ms        = 16'd50;
    thr.long_press_ms      = 16'd1000;
    thr.very_long_press_ms = 16'd3000;
    thr.repeat_start_ms    = 16'd1500;
    thr.repeat_interval_ms = 16'd200;
    btn           = '0;
    mismatches    = 0;
    words_sent    = 0;
    words_seen    = 0;
    setting_count = 1;
    foreach (event_tally[i]) event_tally[i] = 0;

    // Reset thresholds, active low: a pin at 0 is a press.
    add_row(1'b1, 32'd0,    1'b1, EV_NONE);
    add_row(1'b1, 32'd50,   1'b0, EV_NONE);
    add_row(1'b0, 32'd100,  1'b0, EV_NONE);
    add_row(1'b0, 32'd149,  1'b0, EV_NONE);
    add_row(1'b0, 32'd150,  1'b0, EV_NONE);
    add_row(1'b0, 32'd1149, 1'b1, EV_NONE);
    add_row(1'b0, 32'd1150, 1'b1, EV_LONG);
    add_row(1'b0, 32'd1650, 1'b1, EV_REPEAT);
    add_row(1'b0, 32'd1849, 1'b1, EV_NONE);
    add_row(1'b0, 32'd1850, 1'b1, EV_REPEAT);
    add_row(1'b0, 32'd3150, 1'b1, EV_VERY_LONG);
    add_row(1'b0, 32'd3400, 1'b1, EV_NONE);
    add_row(1'b1, 32'd3500, 1'b0, EV_NONE);
    add_row(1'b1, 32'd3550, 1'b1, EV_RELEASED);
    add_row(1'b0, 32'd4000, 1'b0, EV_NONE);
    add_row(1'b0, 32'd4050, 1'b0, EV_NONE);
    add_row(1'b1, 32'd4100, 1'b0, EV_NONE);
    add_row(1'b1, 32'd4150, 1'b1, EV_SHORT);
    // A press across the timestamp wrap, then a jump backwards while held.
    add_row(1'b0, 32'hFFFF_FFF0, 1'b0, EV_NONE);
    add_row(1'b0, 32'h0000_0022, 1'b0, EV_NONE);
    add_row(1'b0, 32'h0000_040A, 1'b1, EV_LONG);
    add_row(1'b0, 32'h0000_0000, 1'b0, EV_NONE);
    add_row(1'b1, 32'hFFFF_FFFF, 1'b0, EV_NONE);
    add_row(1'b1, 32'h0000_0031, 1'b1, EV_RELEASED);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (sample_rows[i])
      send_sample(sample_rows[i].pin, sample_rows[i].now_ms, sample_rows[i].typed,
                  sample_rows[i].ev);
    cur_ms = 32'h0000_0040;

    wait_for_results();
    program_regs(1'b0, 16'd5, 16'd40, 16'd120, 16'd60, 16'd10);
    run_random(300);

    wait_for_results();
    program_regs(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random(250);

    // Spare register indexes must leave the thresholds alone.
    wait_for_results();
    write_reg(CFG_SPARE_LO, 16'($urandom()));
    write_reg(CFG_SPARE_HI, 16'($urandom()));
    program_regs(1'b0, 16'd30, 16'd200, 16'd100, 16'd0, 16'd0);
    run_random(250);

    wait_for_results();
    program_regs(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(250);

    wait_for_results();
    program_regs(1'b0, 16'd2, 16'd0, 16'hFFFF, 16'd5, 16'hFFFF);
    run_random(200);

    repeat (4) begin
      wait_for_results();
      program_regs(1'($urandom_range(0, 1)), rand_ms(), rand_ms(), rand_ms(), rand_ms(),
                   rand_ms());
      run_random(150);
    end

    wait_for_results();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d results from %0d samples under %0d threshold settings.",
             words_seen, words_sent, setting_count);
    $display("Events none/short/long/very long/repeat/released: %0d/%0d/%0d/%0d/%0d/%0d",
             event_tally[EV_NONE], event_tally[EV_SHORT], event_tally[EV_LONG],
             event_tally[EV_VERY_LONG], event_tally[EV_REPEAT], event_tally[EV_RELEASED]);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== button_debounce_press_classifier_core.f =====
rtl/bdpc_pkg.sv
rtl/bdpc_cfg_regs.sv
rtl/bdpc_classify.sv
rtl/button_debounce_press_classifier_core.sv
tb/button_debounce_press_classifier_core_test.sv
